// ----- hw/rtl/xtea_dec_pkg.sv -----
// xtea_dec_pkg: payload types, cipher constants and register indexes
// for the xtea block decrypt pipeline; no dependencies
`timescale 1ns / 1ps

package xtea_dec_pkg;

    localparam int          ROUNDS = 32;
    localparam int          STAGES = 2 * ROUNDS;
    localparam logic [31:0] DELTA  = 32'h9E3779B9;
    localparam int          CFG_INDEX_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        KEY_WORD0 = 3'd0,
        KEY_WORD1 = 3'd1,
        KEY_WORD2 = 3'd2,
        KEY_WORD3 = 3'd3
    } cfg_index_t;

    // input transfer payload
    typedef struct packed {
        logic [31:0] cipher_first;
        logic [31:0] cipher_second;
    } cipher_t;

    // output transfer payload
    typedef struct packed {
        logic [31:0] plain_first;
        logic [31:0] plain_second;
    } plain_t;

    // working pair carried along the cell chain
    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
    } word_pair_t;

    // running sum seen by half-round h (even: second update, odd: first update)
    function automatic logic [31:0] half_sum(input int h);
        int          rounds_left;
        logic [63:0] prod;
        rounds_left = ROUNDS - (h >> 1) - (h & 1);
        prod        = 64'(DELTA) * 64'(rounds_left);
        return prod[31:0];
    endfunction

    // key word picked by half-round h
    function automatic logic [1:0] half_key_sel(input int h);
        logic [31:0] s;
        s = half_sum(h);
        return ((h & 1) == 1) ? s[1:0] : s[12:11];
    endfunction

endpackage

// ----- hw/rtl/xtea_dec_cell.sv -----
// xtea_dec_cell: one half-round of the xtea inverse with its stage register
// depends on xtea_dec_pkg
`timescale 1ns / 1ps

module xtea_dec_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     odd_half,
    input  logic [31:0]              round_sum,
    input  logic [31:0]              key_word,
    input  logic                     prev_valid,
    input  xtea_dec_pkg::word_pair_t prev_data,
    output logic                     valid,
    output xtea_dec_pkg::word_pair_t data
);
    import xtea_dec_pkg::*;

    logic        valid_reg;
    word_pair_t  data_reg;
    word_pair_t  data_next;
    logic [31:0] src;
    logic [31:0] mix;
    logic [31:0] sum_key;
    logic [31:0] f;

    // mixing function on the word that is not updated
    always_comb
    begin
        src       = odd_half ? prev_data.second : prev_data.first;
        mix       = ((src << 4) ^ (src >> 5)) + src;
        sum_key   = round_sum + key_word;
        f         = mix ^ sum_key;
        data_next = prev_data;
        if (odd_half)
        begin
            data_next.first = prev_data.first - f;
        end
        else
        begin
            data_next.second = prev_data.second - f;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ----- hw/rtl/xtea_block_decrypt.sv -----
// xtea_block_decrypt: fully pipelined xtea decryption, one cell per half-round
// depends on xtea_dec_pkg and xtea_dec_cell
//
// Usage:
//   cipher channel: cipher_valid / cipher_stall / cipher carry one 64-bit
//   ciphertext block per transfer; plain channel returns the plaintext block.
//   Key words are written through cfg_valid / cfg_ready / cfg_index / cfg_data
//   (index 0..3, other indexes ignored); cfg_ready is always high. Write the
//   key only while no block is in flight.
//   Path: an input transfer passes the chain of 2*ROUNDS half-round cell
//   registers and then the output register before plain_valid rises.
//   Throughput: one block per cycle while the receiver takes results.
//   Stall: when plain_stall holds a result, one more block lands in the skid
//   register; then cipher_stall rises (registered) and the chain freezes.
//   Reset: clears all valids and the key to zero; the block is ready at once.
`timescale 1ns / 1ps

module xtea_block_decrypt (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cipher_valid,
    output logic                                    cipher_stall,
    input  xtea_dec_pkg::cipher_t                   cipher,
    output logic                                    plain_valid,
    input  logic                                    plain_stall,
    output xtea_dec_pkg::plain_t                    plain,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [xtea_dec_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                             cfg_data
);
    import xtea_dec_pkg::*;

    logic [31:0] key_reg [0:3];
    logic        advance;
    logic        take;
    logic        stage_valid [0:STAGES];
    word_pair_t  stage_data  [0:STAGES];
    logic        out_valid_reg;
    logic        out_valid_next;
    word_pair_t  out_data_reg;
    word_pair_t  out_data_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    word_pair_t  skid_data_reg;
    word_pair_t  skid_data_next;

    // key registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= '0;
            key_reg[1] <= '0;
            key_reg[2] <= '0;
            key_reg[3] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                KEY_WORD0: key_reg[0] <= cfg_data;
                KEY_WORD1: key_reg[1] <= cfg_data;
                KEY_WORD2: key_reg[2] <= cfg_data;
                KEY_WORD3: key_reg[3] <= cfg_data;
                default:   ;
            endcase
        end
    end

    // chain moves whenever the skid register is free
    assign advance      = !skid_valid_reg;
    assign cipher_stall = skid_valid_reg;
    assign take         = out_valid_reg && !plain_stall;

    assign stage_valid[0]       = cipher_valid;
    assign stage_data[0].first  = cipher.cipher_first;
    assign stage_data[0].second = cipher.cipher_second;

    // chain of half-round cells
    for (genvar h = 0; h < STAGES; h++)
    begin : g_cell
        localparam logic [31:0] SUM  = half_sum(h);
        localparam logic [1:0]  KSEL = half_key_sel(h);
        localparam logic        ODD  = ((h % 2) == 1);

        xtea_dec_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .odd_half   (ODD),
            .round_sum  (SUM),
            .key_word   (key_reg[KSEL]),
            .prev_valid (stage_valid[h]),
            .prev_data  (stage_data[h]),
            .valid      (stage_valid[h+1]),
            .data       (stage_data[h+1])
        );
    end

    // output register and skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (stage_valid[STAGES])
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = stage_data[STAGES];
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = stage_data[STAGES];
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign plain_valid        = out_valid_reg;
    assign plain.plain_first  = out_data_reg.first;
    assign plain.plain_second = out_data_reg.second;

    // skid holds a block only behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full with empty output register");

    // skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !$past(skid_valid_reg)) |-> $past(out_valid_reg && plain_stall))
        else $error("skid filled without a stalled output");

    // a transfer out of a full skid presents the skid block next
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !plain_stall) |=> (out_data_reg == $past(skid_data_reg)))
        else $error("skid block lost on drain");

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for the xtea_block_decrypt pipeline
// depends on xtea_dec_pkg and the xtea_block_decrypt rtl; no files or arguments
// a local xtea decryption predictor checks every plaintext block in order
`timescale 1ns / 1ps

module tb_top;

    import xtea_dec_pkg::*;

    localparam int KEY_WORDS    = 4;
    localparam int INDEX_SPAN   = 1 << CFG_INDEX_W;
    localparam int PIPE_LATENCY = 2 * ROUNDS + 1;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASE_BLOCKS = 380;
    localparam int PRESS_BLOCKS = 200;
    localparam int HOLD_CYCLES  = 400;

    logic                   clk;
    logic                   rst_n;
    logic                   cipher_valid;
    logic                   cipher_stall;
    cipher_t                cipher;
    logic                   plain_valid;
    logic                   plain_stall;
    plain_t                 plain;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;

    // key copy used by the predictor
    logic [31:0] key_copy [KEY_WORDS];

    // plaintext blocks still owed by the pipeline, oldest first
    plain_t expected_plain [$];

    int fail_count;
    int sender_gap_pct;
    int receiver_stall_pct;
    int hold_off_left;

    xtea_block_decrypt DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cipher_valid (cipher_valid),
        .cipher_stall (cipher_stall),
        .cipher       (cipher),
        .plain_valid  (plain_valid),
        .plain_stall  (plain_stall),
        .plain        (plain),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock generation
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, well above the slowest correct run
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // one half-round mixing term
    function automatic logic [31:0] feistel_mix(input logic [31:0] x,
                                                input logic [31:0] s,
                                                input logic [31:0] k);
        logic [31:0] f;
        f = ((x << 4) ^ (x >> 5)) + x;
        return f ^ (s + k);
    endfunction

    // full xtea decryption under the current key copy
    function automatic plain_t xtea_decrypt_block(input cipher_t blk);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] s;
        plain_t      res;
        v0 = blk.cipher_first;
        v1 = blk.cipher_second;
        s  = '0;
        for (int r = 0; r < ROUNDS; r++)
            s = s + DELTA;
        for (int r = 0; r < ROUNDS; r++)
        begin
            v1 = v1 - feistel_mix(v0, s, key_copy[s[12:11]]);
            s  = s - DELTA;
            v0 = v0 - feistel_mix(v1, s, key_copy[s[1:0]]);
        end
        res.plain_first  = v0;
        res.plain_second = v1;
        return res;
    endfunction

    task automatic note_failure(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("mismatch %0s: expected %08h, got %08h", what, want, got);
    endtask

    // one key register write; valid is lowered after the transfer
    task automatic write_key_reg(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < KEY_WORDS)
            key_copy[idx[1:0]] = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
        write_key_reg(KEY_WORD0, k0);
        write_key_reg(KEY_WORD1, k1);
        write_key_reg(KEY_WORD2, k2);
        write_key_reg(KEY_WORD3, k3);
    endtask

    // offer one block, with random gaps before it, and log its plaintext
    task automatic send_block(input logic [31:0] w0, input logic [31:0] w1);
        cipher_t blk;
        blk.cipher_first  = w0;
        blk.cipher_second = w1;
        while ($urandom_range(99, 0) < sender_gap_pct)
        begin
            cipher_valid <= 1'b0;
            @(posedge clk);
        end
        cipher_valid <= 1'b1;
        cipher       <= blk;
        @(posedge clk);
        while (cipher_stall)
            @(posedge clk);
        expected_plain.push_back(xtea_decrypt_block(blk));
    endtask

    // stop offering and wait for every owed block to come back
    task automatic drain_pipeline();
        cipher_valid <= 1'b0;
        @(posedge clk);
        while (expected_plain.size() != 0)
            @(posedge clk);
    endtask

    // random word, biased now and then towards the extremes
    function automatic logic [31:0] random_word();
        case ($urandom_range(15, 0))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // result transfers: compare with the oldest expectation, then drive stall
    initial
    begin : result_check
        plain_t want;
        plain_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && plain_valid && !plain_stall)
            begin
                if (expected_plain.size() == 0)
                    note_failure("unexpected result, first word", '0, plain.plain_first);
                else
                begin
                    want = expected_plain.pop_front();
                    if (plain.plain_first !== want.plain_first)
                        note_failure("plain_first", want.plain_first, plain.plain_first);
                    if (plain.plain_second !== want.plain_second)
                        note_failure("plain_second", want.plain_second, plain.plain_second);
                end
            end
            if (hold_off_left > 0)
            begin
                plain_stall <= 1'b1;
                hold_off_left--;
            end
            else
                plain_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
        end
    end

    // reset key: all-zero key words until written, field extremes
    task automatic test_default_key();
        send_block('0, '0);
        send_block('1, '1);
        send_block('0, '1);
        send_block('1, '0);
        send_block(32'hAAAA_AAAA, 32'h5555_5555);
        send_block(32'h0000_0001, 32'h8000_0000);
        drain_pipeline();
    endtask

    // key extremes and a key with every word distinct
    task automatic test_key_extremes();
        load_key('1, '1, '1, '1);
        send_block('0, '0);
        send_block('1, '1);
        send_block(32'h5555_5555, 32'hAAAA_AAAA);
        send_block(32'h8000_0000, 32'h0000_0001);
        drain_pipeline();
        load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
        send_block(32'h4142_4344, 32'h4546_4748);
        send_block('1, '0);
        send_block(32'hDEAD_BEEF, 32'h0123_4567);
        drain_pipeline();
    endtask

    // writes to indexes past the key words must leave the key alone
    task automatic test_unused_indexes();
        for (int i = KEY_WORDS; i < INDEX_SPAN; i++)
            write_key_reg(i[CFG_INDEX_W-1:0], $urandom());
        send_block('0, '0);
        send_block(32'h1234_5678, 32'h9ABC_DEF0);
        drain_pipeline();
    endtask

    // random blocks under a fresh random key, for one idling pattern
    task automatic test_random_phase(input int gap_pct, input int stall_pct);
        drain_pipeline();
        sender_gap_pct     = gap_pct;
        receiver_stall_pct = stall_pct;
        load_key(random_word(), random_word(), random_word(), random_word());
        write_key_reg(CFG_INDEX_W'($urandom_range(INDEX_SPAN - 1, KEY_WORDS)),
                      $urandom());
        for (int n = 0; n < PHASE_BLOCKS; n++)
            send_block(random_word(), random_word());
        drain_pipeline();
    endtask

    // long receiver hold-off while blocks keep coming, so the pipeline fills
    task automatic test_backpressure();
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        hold_off_left      = HOLD_CYCLES;
        for (int n = 0; n < PRESS_BLOCKS; n++)
            send_block($urandom(), $urandom());
        drain_pipeline();
    endtask

    // main sequence
    initial
    begin
        fail_count         = 0;
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        hold_off_left      = 0;
        for (int i = 0; i < KEY_WORDS; i++)
            key_copy[i] = '0;
        rst_n        <= 1'b0;
        cipher_valid <= 1'b0;
        cipher       <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_key();
        test_key_extremes();
        test_unused_indexes();
        test_random_phase(0, 0);
        test_random_phase(50, 0);
        test_random_phase(0, 50);
        test_random_phase(38, 38);
        test_backpressure();

        drain_pipeline();
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
